FILE: src/mc_pkg.sv
// ----------------------------------------------------------------------------
// mc_pkg - shared definitions for the maze carver
// Field widths, codes, register defaults and the direction choice functions.
// ----------------------------------------------------------------------------
package mc_pkg;

    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 16;

    localparam int COL_W      = 6;
    localparam int ROW_W      = 4;
    localparam int RND_W      = 16;
    localparam int COLS_REG_W = 7;
    localparam int ROWS_REG_W = 5;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int TAG_W      = 4;

    localparam logic [COLS_REG_W-1:0] COLS_RESET = 7'd38;
    localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 5'd9;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    localparam logic [1:0] STATUS_START  = 2'd0;
    localparam logic [1:0] STATUS_CARVED = 2'd1;
    localparam logic [1:0] STATUS_DONE   = 2'd2;

    // 4 = 1 mod 3: fold base-4 digits, then fold once more
    function automatic logic [1:0] mod3_16(input logic [RND_W-1:0] v);
        logic [4:0] s1;
        logic [2:0] s2;
        s1 = '0;
        for (int i = 0; i < RND_W / 2; i++)
        begin
            s1 = s1 + 5'(v[2*i +: 2]);
        end
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
        if (s2 >= 3'd6)
            s2 = s2 - 3'd6;
        else if (s2 >= 3'd3)
            s2 = s2 - 3'd3;
        return s2[1:0];
    endfunction

    // random word modulo the number of open directions
    function automatic logic [1:0] rnd_index(input logic [3:0] cand,
                                             input logic [RND_W-1:0] rnd);
        logic [1:0] k;
        case ($countones(cand))
            2:       k = {1'b0, rnd[0]};
            3:       k = mod3_16(rnd);
            4:       k = rnd[1:0];
            default: k = 2'd0;
        endcase
        return k;
    endfunction

    // direction of the k-th open candidate, in order up, right, down, left
    function automatic logic [1:0] pick_dir(input logic [3:0] cand,
                                            input logic [1:0] k);
        logic [2:0] seen;
        logic [1:0] dir;
        logic       found;
        seen  = '0;
        dir   = DIR_UP;
        found = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (cand[i] && !found)
            begin
                if (seen == 3'(k))
                begin
                    dir   = 2'(i);
                    found = 1'b1;
                end
                seen = seen + 3'd1;
            end
        end
        return dir;
    endfunction

endpackage

FILE: src/mc_if.sv
// ----------------------------------------------------------------------------
// mc_if - channel interfaces of the maze carver
// Item channel (commands) and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface mc_in_if import mc_pkg::*;;
    logic             valid;
    logic             ready;
    logic             op;
    logic [COL_W-1:0] start_col;
    logic [ROW_W-1:0] start_row;
    logic [RND_W-1:0] random_word;

    modport source (output valid, output op, output start_col, output start_row,
                    output random_word, input ready);
    modport sink   (input valid, input op, input start_col, input start_row,
                    input random_word, output ready);
endinterface

interface mc_out_if import mc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] cell_col;
    logic [ROW_W-1:0] cell_row;
    logic [1:0]       direction;
    logic [1:0]       status;

    modport source (output valid, output cell_col, output cell_row,
                    output direction, output status, input ready);
    modport sink   (input valid, input cell_col, input cell_row,
                    input direction, input status, output ready);
endinterface

FILE: src/mc_ram.sv
// ----------------------------------------------------------------------------
// mc_ram - simple dual-port memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mc_ram
    import mc_pkg::*;
#(
    parameter int DW = 10,
    parameter int AW = 10
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [(1 << AW)];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

FILE: src/mc_nbr_unit.sv
// ----------------------------------------------------------------------------
// mc_nbr_unit - neighbor address unit
// Step from a cell in one direction and check the step against the grid.
// ----------------------------------------------------------------------------
module mc_nbr_unit
    import mc_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    localparam int CW  = $clog2(MAX_COLS),
    localparam int RW  = $clog2(MAX_ROWS),
    localparam int NCW = $clog2(MAX_COLS + 1),
    localparam int NRW = $clog2(MAX_ROWS + 1)
)
(
    input  logic [CW-1:0]  col,
    input  logic [RW-1:0]  row,
    input  logic [1:0]     dir,
    input  logic [NCW-1:0] nc,
    input  logic [NRW-1:0] nr,
    output logic           ok,
    output logic [CW-1:0]  ncol,
    output logic [RW-1:0]  nrow
);

    always_comb
    begin
        ok   = 1'b0;
        ncol = col;
        nrow = row;
        unique case (dir)
            DIR_UP:
            begin
                ok   = (row != '0);
                nrow = row - 1'b1;
            end
            DIR_RIGHT:
            begin
                ok   = (32'(col) + 32'd1 < 32'(nc));
                ncol = col + 1'b1;
            end
            DIR_DOWN:
            begin
                ok   = (32'(row) + 32'd1 < 32'(nr));
                nrow = row + 1'b1;
            end
            DIR_LEFT:
            begin
                ok   = (col != '0);
                ncol = col - 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

endmodule

FILE: src/maze_carver.sv
// ----------------------------------------------------------------------------
// maze_carver - depth-first maze carver
// Backtracking maze generator with an explicit cell stack and a tagged
// visited map; one result per command.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  in_ch    | in  | op, start_col, start_row, random_word
//  out_ch   | out | cell_col, cell_row, direction, status
//  cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
//  Start: every 15th start adds a sweep that clears the visited map tags.
//  Step: for each examined stack cell, its in-bound neighbors are checked one
//  by one through the single read port of the visited map.
//  Reset clears control state only. A result waiting on out_ch holds the
//  next result back, not the next command.
// ----------------------------------------------------------------------------
module maze_carver
    import mc_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mc_in_if.sink                 in_ch,
    mc_out_if.source              out_ch
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int AW  = CW + RW;
    localparam int SPW = AW + 1;
    localparam int NCW = $clog2(MAX_COLS + 1);
    localparam int NRW = $clog2(MAX_ROWS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_TOP   = 4'd3;
    localparam logic [3:0] S_TOPW  = 4'd4;
    localparam logic [3:0] S_NB    = 4'd5;
    localparam logic [3:0] S_NBW   = 4'd6;
    localparam logic [3:0] S_PICK  = 4'd7;
    localparam logic [3:0] S_CARVE = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]            state_reg, state_next;
    logic [COLS_REG_W-1:0] cols_in_use_reg;
    logic [ROWS_REG_W-1:0] rows_in_use_reg;
    logic [SPW-1:0]        sp_reg, sp_next;
    logic [TAG_W-1:0]      epoch_reg, epoch_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic [CW-1:0]         col_reg, col_next;
    logic [RW-1:0]         row_reg, row_next;
    logic [1:0]            dir_reg, dir_next;
    logic [3:0]            cand_reg, cand_next;
    logic [RND_W-1:0]      rnd_reg, rnd_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COL_W-1:0]      out_col_reg, out_col_next;
    logic [ROW_W-1:0]      out_row_reg, out_row_next;
    logic [1:0]            out_dir_reg, out_dir_next;
    logic [1:0]            out_status_reg, out_status_next;

    logic [NCW-1:0]   nc;
    logic [NRW-1:0]   nr;
    logic [CW-1:0]    start_c;
    logic [RW-1:0]    start_r;
    logic             out_free;
    logic             nb_ok;
    logic [CW-1:0]    nb_col;
    logic [RW-1:0]    nb_row;
    logic             vis_we;
    logic [AW-1:0]    vis_waddr;
    logic [TAG_W-1:0] vis_wdata;
    logic [TAG_W-1:0] vis_rdata;
    logic             stk_we;
    logic [AW-1:0]    stk_waddr;
    logic [AW-1:0]    stk_wdata;
    logic [AW-1:0]    stk_raddr;
    logic [AW-1:0]    stk_rdata;

    // effective grid size and saturated start cell
    always_comb
    begin
        if (cols_in_use_reg == '0)
            nc = NCW'(1);
        else if (32'(cols_in_use_reg) > MAX_COLS)
            nc = NCW'(MAX_COLS);
        else
            nc = NCW'(cols_in_use_reg);

        if (rows_in_use_reg == '0)
            nr = NRW'(1);
        else if (32'(rows_in_use_reg) > MAX_ROWS)
            nr = NRW'(MAX_ROWS);
        else
            nr = NRW'(rows_in_use_reg);

        if (32'(in_ch.start_col) >= 32'(nc))
            start_c = CW'(nc - 1'b1);
        else
            start_c = CW'(in_ch.start_col);

        if (32'(in_ch.start_row) >= 32'(nr))
            start_r = RW'(nr - 1'b1);
        else
            start_r = RW'(in_ch.start_row);
    end

    mc_nbr_unit #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_nbr (
        .col  (col_reg),
        .row  (row_reg),
        .dir  (dir_reg),
        .nc   (nc),
        .nr   (nr),
        .ok   (nb_ok),
        .ncol (nb_col),
        .nrow (nb_row)
    );

    mc_ram #(
        .DW (TAG_W),
        .AW (AW)
    ) u_visited (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr ({nb_row, nb_col}),
        .rdata (vis_rdata)
    );

    mc_ram #(
        .DW (AW),
        .AW (AW)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign out_free     = !out_valid_reg || out_ch.ready;
    assign stk_raddr    = AW'(sp_reg - 1'b1);
    assign in_ch.ready  = (state_reg == S_IDLE);

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.cell_col  = out_col_reg;
    assign out_ch.cell_row  = out_row_reg;
    assign out_ch.direction = out_dir_reg;
    assign out_ch.status    = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        sp_next         = sp_reg;
        epoch_next      = epoch_reg;
        clr_next        = clr_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        dir_next        = dir_reg;
        cand_next       = cand_reg;
        rnd_next        = rnd_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        out_dir_next    = out_dir_reg;
        out_status_next = out_status_reg;
        vis_we          = 1'b0;
        vis_waddr       = {row_reg, col_reg};
        vis_wdata       = epoch_reg;
        stk_we          = 1'b0;
        stk_waddr       = '0;
        stk_wdata       = {row_reg, col_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    rnd_next = in_ch.random_word;
                    if (in_ch.op == OP_START)
                    begin
                        col_next = start_c;
                        row_next = start_r;
                        if (epoch_reg == '1)
                        begin
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + 1'b1;
                            state_next = S_START;
                        end
                    end
                    else if (sp_reg == '0)
                        state_next = S_DONE;
                    else
                        state_next = S_TOP;
                end
            end
            S_CLEAR:
            begin
                vis_we    = 1'b1;
                vis_waddr = clr_reg;
                vis_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    epoch_next = TAG_W'(1);
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (out_free)
                begin
                    vis_we          = 1'b1;
                    stk_we          = 1'b1;
                    sp_next         = SPW'(1);
                    out_valid_next  = 1'b1;
                    out_col_next    = COL_W'(col_reg);
                    out_row_next    = ROW_W'(row_reg);
                    out_dir_next    = DIR_UP;
                    out_status_next = STATUS_START;
                    state_next      = S_IDLE;
                end
            end
            S_TOP:
            begin
                state_next = S_TOPW;
            end
            S_TOPW:
            begin
                {row_next, col_next} = stk_rdata;
                dir_next   = DIR_UP;
                cand_next  = '0;
                state_next = S_NB;
            end
            S_NB:
            begin
                if (nb_ok)
                    state_next = S_NBW;
                else if (dir_reg == DIR_LEFT)
                    state_next = S_PICK;
                else
                    dir_next = dir_reg + 1'b1;
            end
            S_NBW:
            begin
                if (vis_rdata != epoch_reg)
                    cand_next[dir_reg] = 1'b1;
                if (dir_reg == DIR_LEFT)
                    state_next = S_PICK;
                else
                begin
                    dir_next   = dir_reg + 1'b1;
                    state_next = S_NB;
                end
            end
            S_PICK:
            begin
                if (cand_reg == '0)
                begin
                    sp_next = sp_reg - 1'b1;
                    if (sp_reg == SPW'(1))
                        state_next = S_DONE;
                    else
                        state_next = S_TOP;
                end
                else
                begin
                    dir_next   = pick_dir(cand_reg, rnd_index(cand_reg, rnd_reg));
                    state_next = S_CARVE;
                end
            end
            S_CARVE:
            begin
                if (out_free)
                begin
                    vis_we          = 1'b1;
                    vis_waddr       = {nb_row, nb_col};
                    stk_we          = 1'b1;
                    stk_waddr       = sp_reg[AW-1:0];
                    stk_wdata       = {nb_row, nb_col};
                    sp_next         = sp_reg + 1'b1;
                    out_valid_next  = 1'b1;
                    out_col_next    = COL_W'(nb_col);
                    out_row_next    = ROW_W'(nb_row);
                    out_dir_next    = dir_reg;
                    out_status_next = STATUS_CARVED;
                    state_next      = S_IDLE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    sp_next         = '0;
                    out_valid_next  = 1'b1;
                    out_col_next    = '0;
                    out_row_next    = '0;
                    out_dir_next    = DIR_UP;
                    out_status_next = STATUS_DONE;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            sp_reg          <= '0;
            epoch_reg       <= '1;
            out_valid_reg   <= 1'b0;
            cols_in_use_reg <= COLS_RESET;
            rows_in_use_reg <= ROWS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            epoch_reg     <= epoch_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_COLS: cols_in_use_reg <= cfg_data[COLS_REG_W-1:0];
                    CFG_ROWS: rows_in_use_reg <= cfg_data[ROWS_REG_W-1:0];
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        clr_reg        <= clr_next;
        col_reg        <= col_next;
        row_reg        <= row_next;
        dir_reg        <= dir_next;
        cand_reg       <= cand_next;
        rnd_reg        <= rnd_next;
        out_col_reg    <= out_col_next;
        out_row_reg    <= out_row_next;
        out_dir_reg    <= out_dir_next;
        out_status_reg <= out_status_next;
    end

endmodule

FILE: src/mc_checker.sv
// ----------------------------------------------------------------------------
// mc_checker - port-level checks for the maze carver
// Watches the channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module mc_checker
    import mc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [COL_W-1:0] cell_col,
    input logic [ROW_W-1:0] cell_row,
    input logic [1:0]       direction,
    input logic [1:0]       status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell_col)
            && $stable(cell_row) && $stable(direction) && $stable(status))
        else $error("result dropped or changed while stalled");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("command taken while previous one in work");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_DONE |->
            cell_col == '0 && cell_row == '0 && direction == DIR_UP)
        else $error("finished result carries a cell");

    a_start_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_START |-> direction == DIR_UP)
        else $error("start result carries a direction");

endmodule

bind maze_carver mc_checker u_mc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cell_col  (out_ch.cell_col),
    .cell_row  (out_ch.cell_row),
    .direction (out_ch.direction),
    .status    (out_ch.status)
);

FILE: dv/mc_carve_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mc_carve_checker - scoreboard for the maze carver
// Watches the command, result and register ports, carries its own copy of
// the visited map, cell stack and size registers, predicts one result per
// accepted command and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module mc_carve_checker
    import mc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mc_in_if                      in_ch,
    mc_out_if                     out_ch,
    output int                    fail_count,
    output int                    pending
);

    localparam int NUM_CELLS = MAX_COLS_DEF * MAX_ROWS_DEF;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [1:0]       dir;
        logic [1:0]       status;
    } carve_result_t;

    bit                   visited [NUM_CELLS];
    logic [9:0]           path_cells [NUM_CELLS];
    int                   path_depth;
    logic [COLS_REG_W-1:0] cols_reg;
    logic [ROWS_REG_W-1:0] rows_reg;
    carve_result_t        carve_expected [$];

    function automatic int clamp_size(input int v, input int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic bit neighbor_of(input int c, input int r, input logic [1:0] dir,
                                       input int nc, input int nr,
                                       output int oc, output int orow);
        oc   = c;
        orow = r;
        case (dir)
            DIR_UP:
            begin
                if (r == 0)
                    return 1'b0;
                orow = r - 1;
            end
            DIR_RIGHT:
            begin
                if (c + 1 >= nc)
                    return 1'b0;
                oc = c + 1;
            end
            DIR_DOWN:
            begin
                if (r + 1 >= nr)
                    return 1'b0;
                orow = r + 1;
            end
            default:
            begin
                if (c == 0)
                    return 1'b0;
                oc = c - 1;
            end
        endcase
        return 1'b1;
    endfunction

    task automatic predict_carve(input logic op, input logic [COL_W-1:0] sc,
                                 input logic [ROW_W-1:0] sr, input logic [RND_W-1:0] rnd,
                                 output carve_result_t res);
        int         nc;
        int         nr;
        int         c;
        int         r;
        int         top_cell;
        int         cnt;
        int         nx;
        int         ny;
        bit         carved;
        logic [1:0] dir;
        logic [1:0] cand [4];
        nc  = clamp_size(int'(cols_reg), MAX_COLS_DEF);
        nr  = clamp_size(int'(rows_reg), MAX_ROWS_DEF);
        res = '0;
        if (op == OP_START)
        begin
            c = int'(sc);
            r = int'(sr);
            if (c >= nc)
                c = nc - 1;
            if (r >= nr)
                r = nr - 1;
            foreach (visited[i])
                visited[i] = 1'b0;
            visited[r * MAX_COLS_DEF + c] = 1'b1;
            path_cells[0] = 10'(r * MAX_COLS_DEF + c);
            path_depth    = 1;
            res.col       = COL_W'(c);
            res.row       = ROW_W'(r);
            res.dir       = DIR_UP;
            res.status    = STATUS_START;
        end
        else
        begin
            carved = 1'b0;
            while (path_depth > 0 && !carved)
            begin
                top_cell = int'(path_cells[path_depth - 1]);
                c   = top_cell % MAX_COLS_DEF;
                r   = top_cell / MAX_COLS_DEF;
                cnt = 0;
                for (int k = 0; k < 4; k++)
                begin
                    if (neighbor_of(c, r, 2'(k), nc, nr, nx, ny) &&
                        !visited[ny * MAX_COLS_DEF + nx])
                    begin
                        cand[cnt] = 2'(k);
                        cnt++;
                    end
                end
                if (cnt == 0)
                begin
                    path_depth--;
                end
                else
                begin
                    dir = cand[int'(rnd) % cnt];
                    void'(neighbor_of(c, r, dir, nc, nr, nx, ny));
                    visited[ny * MAX_COLS_DEF + nx] = 1'b1;
                    path_cells[path_depth] = 10'(ny * MAX_COLS_DEF + nx);
                    path_depth++;
                    res.col    = COL_W'(nx);
                    res.row    = ROW_W'(ny);
                    res.dir    = dir;
                    res.status = STATUS_CARVED;
                    carved     = 1'b1;
                end
            end
            if (!carved)
            begin
                path_depth = 0;
                res.status = STATUS_DONE;
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        carve_result_t res;
        if (!rst_n)
        begin
            foreach (visited[i])
                visited[i] = 1'b0;
            path_depth = 0;
            cols_reg   = COLS_RESET;
            rows_reg   = ROWS_RESET;
            carve_expected.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_COLS)
                    cols_reg = COLS_REG_W'(cfg_data);
                else if (cfg_index == CFG_ROWS)
                    rows_reg = ROWS_REG_W'(cfg_data);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (carve_expected.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d",
                             $time, out_ch.cell_col, out_ch.cell_row, out_ch.direction,
                             out_ch.status);
                end
                else
                begin
                    res = carve_expected.pop_front();
                    check_field("status", int'(res.status), int'(out_ch.status));
                    check_field("cell_col", int'(res.col), int'(out_ch.cell_col));
                    check_field("cell_row", int'(res.row), int'(out_ch.cell_row));
                    check_field("direction", int'(res.dir), int'(out_ch.direction));
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                predict_carve(in_ch.op, in_ch.start_col, in_ch.start_row,
                              in_ch.random_word, res);
                carve_expected.push_back(res);
            end
            pending = carve_expected.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - maze carver testbench
// Drives start and step commands over the item channel, writes the grid size
// registers between phases (clamped, degenerate and full sizes), throttles
// both channels at random and leaves the checking to the scoreboard.
// ----------------------------------------------------------------------------
module tb_top
    import mc_pkg::*;
();

    localparam int DIRECTED_ITEMS = 27;
    localparam int RANDOM_ITEMS   = 750;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int TAIL_CYCLES    = 64;
    localparam int HOLD_AT_RESULT = 300;
    localparam int HOLD_CYCLES    = 400;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int starts_sent;
    int steps_sent;
    int size_settings;
    int cycles;

    mc_in_if  in_ch ();
    mc_out_if out_ch ();

    maze_carver DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    mc_carve_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random back-pressure, one long hold-off mid-run
    initial
    begin
        int got;
        int hold_left;
        got       = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                got++;
                if (got == HOLD_AT_RESULT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic issue_command(input logic op, input int col, input int row, input int rnd);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= op;
        in_ch.start_col   <= COL_W'(col);
        in_ch.start_row   <= ROW_W'(row);
        in_ch.random_word <= RND_W'(rnd);
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
        if (op == OP_START)
            starts_sent++;
        else
            steps_sent++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_size(input int cols, input int rows);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_COLS;
        cfg_data  <= CFG_DATA_W'(cols);
        @(posedge clk);
        cfg_index <= CFG_ROWS;
        cfg_data  <= CFG_DATA_W'(rows);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        size_settings++;
    endtask

    initial
    begin
        int col_extremes [5];
        int row_extremes [5];
        int cols;
        int rows;
        int eff_c;
        int eff_r;
        int nsteps;
        int roll;
        int rnd;
        int random_base;
        bit paused;

        col_extremes = '{0, 1, 64, 65, 127};
        row_extremes = '{0, 1, 16, 17, 31};
        paused        = 1'b0;
        items_sent    = 0;
        starts_sent   = 0;
        steps_sent    = 0;
        size_settings = 0;
        send_idle_pct = 23;
        recv_idle_pct = 46;

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_COLS;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.op          <= OP_START;
        in_ch.start_col   <= '0;
        in_ch.start_row   <= '0;
        in_ch.random_word <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size 38x9: step before any start, corners, saturated start
        issue_command(OP_STEP, 0, 0, $urandom_range(0, 65535));
        issue_command(OP_START, 0, 0, 0);
        issue_command(OP_STEP, 0, 0, 16'h0000);
        issue_command(OP_STEP, 0, 0, 16'hFFFF);
        issue_command(OP_START, 63, 15, 0);
        issue_command(OP_STEP, 0, 0, 16'h5555);
        issue_command(OP_STEP, 0, 0, 16'hAAAA);

        // zero sizes act as a single cell
        drain_results();
        set_size(0, 0);
        issue_command(OP_START, 63, 15, 16'hFFFF);
        issue_command(OP_STEP, 63, 15, 16'hFFFF);
        issue_command(OP_STEP, 0, 0, 0);

        // oversize registers clamp to the full grid
        drain_results();
        set_size(127, 31);
        issue_command(OP_START, 63, 15, 0);
        issue_command(OP_STEP, 0, 0, 16'hFFFF);
        issue_command(OP_STEP, 0, 0, 16'h0000);
        issue_command(OP_START, 0, 15, 0);
        issue_command(OP_STEP, 0, 0, $urandom_range(0, 65535));

        drain_results();
        set_size(1, 16);
        issue_command(OP_START, 0, 0, 0);
        repeat (3) issue_command(OP_STEP, 0, 0, $urandom_range(0, 65535));

        drain_results();
        set_size(2, 1);
        issue_command(OP_START, 1, 0, 0);
        issue_command(OP_STEP, 0, 0, $urandom_range(0, 65535));
        issue_command(OP_STEP, 0, 0, $urandom_range(0, 65535));

        // shrink the grid under a maze in progress
        drain_results();
        set_size(8, 8);
        issue_command(OP_START, 7, 7, 0);
        issue_command(OP_STEP, 0, 0, 16'h0001);
        issue_command(OP_STEP, 0, 0, 16'h0002);
        drain_results();
        set_size(3, 2);
        issue_command(OP_STEP, 0, 0, $urandom_range(0, 65535));
        issue_command(OP_STEP, 0, 0, $urandom_range(0, 65535));

        random_base = items_sent;
        while (items_sent < random_base + RANDOM_ITEMS)
        begin
            drain_results();
            roll = $urandom_range(0, 99);
            if (roll < 10)
            begin
                cols = col_extremes[$urandom_range(0, 4)];
                rows = row_extremes[$urandom_range(0, 4)];
            end
            else if (roll < 15)
            begin
                cols = 64;
                rows = 16;
            end
            else
            begin
                cols = $urandom_range(1, 12);
                rows = $urandom_range(1, 6);
            end
            set_size(cols, rows);
            eff_c = (cols == 0) ? 1 : ((cols > 64) ? 64 : cols);
            eff_r = (rows == 0) ? 1 : ((rows > 16) ? 16 : rows);

            if (items_sent - random_base < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 23;
                recv_idle_pct = 46;
            end
            else if (items_sent - random_base < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 46;
                recv_idle_pct = 23;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if ($urandom_range(0, 99) < 75)
            begin
                if ($urandom_range(0, 1) == 1)
                    issue_command(OP_START, $urandom_range(0, 63), $urandom_range(0, 15), 0);
                else
                    issue_command(OP_START, $urandom_range(0, eff_c - 1),
                                  $urandom_range(0, eff_r - 1), $urandom_range(0, 65535));
            end

            nsteps = $urandom_range(1, (eff_c * eff_r + 4 > 60) ? 60 : eff_c * eff_r + 4);
            for (int i = 0; i < nsteps; i++)
            begin
                if (!paused && items_sent - random_base > 400)
                begin
                    drain_results();
                    paused = 1'b1;
                end
                roll = $urandom_range(0, 99);
                if (roll < 10)
                    rnd = ($urandom_range(0, 1) == 1) ? 32'hFFFF : 32'h0000;
                else
                    rnd = $urandom_range(0, 65535);
                if ($urandom_range(0, 99) < 6)
                    issue_command(OP_START, $urandom_range(0, 63), $urandom_range(0, 15), rnd);
                else
                    issue_command(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 15), rnd);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d commands (%0d starts, %0d steps) over %0d grid sizes,",
                 items_sent, starts_sent, steps_sent, size_settings + 1);
        $display("including single-cell, one-wide, clamped and full 64x16 grids.");
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
